[src/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the plane segment clipper.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int CW            = 32;
    localparam int DIFF_W        = CW + 1;
    localparam int PROD_W        = DIFF_W + CW;
    localparam int DIST_W        = PROD_W + 2;
    localparam int DEN_W         = DIST_W + 1;
    localparam int QBITS         = 31;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PP_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PP_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PP_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_N_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_N_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_N_Z  = 3'd5;

    localparam logic signed [CW-1:0] NORMAL_Z_RESET = 32'sh0001_0000;
    localparam logic signed [CW-1:0] SAT_MAX        = 32'sh7fff_ffff;
    localparam logic signed [CW-1:0] SAT_MIN        = 32'sh8000_0000;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
        logic signed [CW-1:0] hit_z;
        logic signed [CW-1:0] param_t;
        logic                 start_inside;
        logic                 end_inside;
        logic                 is_parallel;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0]     start_x;
        logic signed [CW-1:0]     start_y;
        logic signed [CW-1:0]     start_z;
        logic signed [DIFF_W-1:0] delta_x;
        logic signed [DIFF_W-1:0] delta_y;
        logic signed [DIFF_W-1:0] delta_z;
        logic                     start_inside;
        logic                     end_inside;
        logic                     is_parallel;
    } t_side;

    typedef struct packed {
        logic signed [CW-1:0] pp_x;
        logic signed [CW-1:0] pp_y;
        logic signed [CW-1:0] pp_z;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [CW-1:0] n_z;
    } t_plane;

endpackage

[src/psc_if.sv]
// ----------------------------------------------------------------------------
// psc_if
// Valid/ready channels of the plane segment clipper.
// ----------------------------------------------------------------------------
interface psc_in_if;
    logic          valid;
    logic          ready;
    psc_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psc_out_if;
    logic          valid;
    logic          ready;
    psc_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [psc_pkg::CFG_IDX_W-1:0]  index;
    logic [psc_pkg::CW-1:0]         data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/psc_dist.sv]
// ----------------------------------------------------------------------------
// psc_dist
// Three stages: offsets from the plane point, products with the normal,
// and the two signed distances with their difference.
// ----------------------------------------------------------------------------
module psc_dist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  psc_pkg::t_in                        i_data,
    input  psc_pkg::t_plane                     i_plane,
    output logic                                o_valid,
    output logic signed [psc_pkg::DIST_W-1:0]   o_d0,
    output logic signed [psc_pkg::DEN_W-1:0]    o_den,
    output psc_pkg::t_side                      o_side
);
    import psc_pkg::*;

    logic signed [CW-1:0]     s [3];
    logic signed [CW-1:0]     e [3];
    logic signed [CW-1:0]     pp [3];
    logic signed [CW-1:0]     nrm [3];
    logic signed [DIFF_W-1:0] r1_a [3];
    logic signed [DIFF_W-1:0] r1_b [3];
    logic signed [PROD_W-1:0] r2_p0 [3];
    logic signed [PROD_W-1:0] r2_p1 [3];
    t_side                    r1_side, r2_side, r3_side;
    logic                     r1_v, r2_v, r3_v;
    logic signed [DIST_W-1:0] d0, d1;
    logic signed [DEN_W-1:0]  den;
    logic signed [DIST_W-1:0] r3_d0;
    logic signed [DEN_W-1:0]  r3_den;
    t_side                    n1_side, n3_side;

    assign s[0]   = i_data.start_x;
    assign s[1]   = i_data.start_y;
    assign s[2]   = i_data.start_z;
    assign e[0]   = i_data.end_x;
    assign e[1]   = i_data.end_y;
    assign e[2]   = i_data.end_z;
    assign pp[0]  = i_plane.pp_x;
    assign pp[1]  = i_plane.pp_y;
    assign pp[2]  = i_plane.pp_z;
    assign nrm[0] = i_plane.n_x;
    assign nrm[1] = i_plane.n_y;
    assign nrm[2] = i_plane.n_z;

    always_comb begin
        n1_side              = '0;
        n1_side.start_x      = i_data.start_x;
        n1_side.start_y      = i_data.start_y;
        n1_side.start_z      = i_data.start_z;
        n1_side.delta_x      = DIFF_W'(i_data.end_x) - DIFF_W'(i_data.start_x);
        n1_side.delta_y      = DIFF_W'(i_data.end_y) - DIFF_W'(i_data.start_y);
        n1_side.delta_z      = DIFF_W'(i_data.end_z) - DIFF_W'(i_data.start_z);
    end

    assign d0  = DIST_W'(r2_p0[0]) + DIST_W'(r2_p0[1]) + DIST_W'(r2_p0[2]);
    assign d1  = DIST_W'(r2_p1[0]) + DIST_W'(r2_p1[1]) + DIST_W'(r2_p1[2]);
    assign den = DEN_W'(d0) - DEN_W'(d1);

    always_comb begin
        n3_side              = r2_side;
        n3_side.start_inside = ~d0[DIST_W-1];
        n3_side.end_inside   = ~d1[DIST_W-1];
        n3_side.is_parallel  = (den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_a[i]  <= DIFF_W'(s[i]) - DIFF_W'(pp[i]);
                r1_b[i]  <= DIFF_W'(e[i]) - DIFF_W'(pp[i]);
                r2_p0[i] <= r1_a[i] * nrm[i];
                r2_p1[i] <= r1_b[i] * nrm[i];
            end
            r1_side <= n1_side;
            r2_side <= r1_side;
            r3_side <= n3_side;
            r3_d0   <= d0;
            r3_den  <= den;
        end
    end

    assign o_valid = r3_v;
    assign o_d0    = r3_d0;
    assign o_den   = r3_den;
    assign o_side  = r3_side;

endmodule

[src/psc_div.sv]
// ----------------------------------------------------------------------------
// psc_div
// Pipelined restoring divider for t = d0 * 2^FRAC_BITS / (d0 - d1), one
// quotient bit per stage, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module psc_div #(
    parameter int FRAC_BITS = psc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [psc_pkg::DIST_W-1:0]   i_d0,
    input  logic signed [psc_pkg::DEN_W-1:0]    i_den,
    input  psc_pkg::t_side                      i_side,
    output logic                                o_valid,
    output logic signed [psc_pkg::CW-1:0]       o_t,
    output psc_pkg::t_side                      o_side
);
    import psc_pkg::*;

    localparam int QW = DEN_W + QBITS + 1 + FRAC_BITS;

    logic [DIST_W-1:0]     num_mag;
    logic [DEN_W-1:0]      den_mag;
    logic [QW-1:0]         num_sh;
    logic [QW-1:0]         den_w;
    logic [QW-1:0]         r_n [QBITS+1];
    logic [QW-1:0]         r_d [QBITS+1];
    logic [QBITS-1:0]      r_q [QBITS+1];
    logic                  r_neg [QBITS+1];
    logic                  r_sat [QBITS+1];
    logic                  r_v [QBITS+1];
    t_side                 r_side [QBITS+1];
    logic                  r_out_v;
    logic signed [CW-1:0]  r_t;
    t_side                 r_out_side;
    logic signed [CW-1:0]  n_t;
    logic signed [CW-1:0]  q_ext;

    assign num_mag = i_d0[DIST_W-1] ? DIST_W'(-i_d0) : DIST_W'(i_d0);
    assign den_mag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
    assign num_sh  = QW'(num_mag) << FRAC_BITS;
    assign den_w   = QW'(den_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]    <= num_sh;
            r_d[0]    <= den_w;
            r_q[0]    <= '0;
            r_neg[0]  <= i_d0[DIST_W-1] ^ i_den[DEN_W-1];
            r_sat[0]  <= (num_sh >= (den_w << QBITS));
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_bit
        logic [QW-1:0] sub;
        logic          take;
        assign sub  = r_d[k-1] << (QBITS - k);
        assign take = (r_n[k-1] >= sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]    <= take ? r_n[k-1] - sub : r_n[k-1];
                r_d[k]    <= r_d[k-1];
                r_q[k]    <= r_q[k-1] | (QBITS'(take) << (QBITS - k));
                r_neg[k]  <= r_neg[k-1];
                r_sat[k]  <= r_sat[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign q_ext = CW'(r_q[QBITS]);

    always_comb begin
        if (r_side[QBITS].is_parallel) begin
            n_t = '0;
        end else if (r_sat[QBITS]) begin
            n_t = r_neg[QBITS] ? SAT_MIN : SAT_MAX;
        end else begin
            n_t = r_neg[QBITS] ? -q_ext : q_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[QBITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t        <= n_t;
            r_out_side <= r_side[QBITS];
        end
    end

    assign o_valid = r_out_v;
    assign o_t     = r_t;
    assign o_side  = r_out_side;

endmodule

[src/psc_interp.sv]
// ----------------------------------------------------------------------------
// psc_interp
// Intersection point: (end - start) * t scaled back, plus start, saturated.
// The last stage is the output register.
// ----------------------------------------------------------------------------
module psc_interp #(
    parameter int FRAC_BITS = psc_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [psc_pkg::CW-1:0]   i_t,
    input  psc_pkg::t_side                  i_side,
    output logic                            o_valid,
    output psc_pkg::t_out                   o_data
);
    import psc_pkg::*;

    localparam int SUM_W = PROD_W + 1;

    logic signed [DIFF_W-1:0] dlt [3];
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [CW-1:0]     r_start [3];
    logic signed [CW-1:0]     r_t;
    logic                     r_si, r_ei, r_par;
    logic                     r_mv;
    logic signed [CW-1:0]     hit [3];
    logic                     r_ov;
    t_out                     r_out;
    t_out                     n_out;

    assign dlt[0] = i_side.delta_x;
    assign dlt[1] = i_side.delta_y;
    assign dlt[2] = i_side.delta_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [PROD_W-1:0] sh;
            logic signed [SUM_W-1:0]  sum;
            sh  = r_prod[i] >>> FRAC_BITS;
            sum = SUM_W'(sh) + SUM_W'(r_start[i]);
            if (r_par) begin
                hit[i] = r_start[i];
            end else if (sum > SUM_W'(SAT_MAX)) begin
                hit[i] = SAT_MAX;
            end else if (sum < SUM_W'(SAT_MIN)) begin
                hit[i] = SAT_MIN;
            end else begin
                hit[i] = CW'(sum);
            end
        end
    end

    always_comb begin
        n_out.hit_x        = hit[0];
        n_out.hit_y        = hit[1];
        n_out.hit_z        = hit[2];
        n_out.param_t      = r_t;
        n_out.start_inside = r_si;
        n_out.end_inside   = r_ei;
        n_out.is_parallel  = r_par;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_mv <= i_valid;
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= dlt[i] * i_t;
            end
            r_start[0] <= i_side.start_x;
            r_start[1] <= i_side.start_y;
            r_start[2] <= i_side.start_z;
            r_t        <= i_t;
            r_si       <= i_side.start_inside;
            r_ei       <= i_side.end_inside;
            r_par      <= i_side.is_parallel;
            r_out      <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

[src/plane_segment_clip_top.sv]
// ----------------------------------------------------------------------------
// plane_segment_clip_top
// Clips 3D segments against a configured plane.
// ----------------------------------------------------------------------------
// Usage: the plane point and normal are written over the configuration
// channel (index 0..5: point x, y, z, normal x, y, z) while the block is idle.
// The write channel is always ready; an index beyond the list is ignored.
// Each input beat carries one segment; each output beat carries the hit
// point, the parameter t, both inside flags and the parallel flag.
// Throughput is one segment per cycle while the output beat is not stalled.
// Three stages form the distances, the divider spends one stage per quotient
// bit plus an entry and an exit stage (33), and two stages form the hit point.
// All stages advance together; when the output beat is stalled the whole
// pipeline holds and the input is not ready, while an empty output register
// lets the pipeline advance even when the receiver is not ready. Reset
// empties the pipeline and loads the default plane (origin, normal along +z).
// ----------------------------------------------------------------------------
module plane_segment_clip_top #(
    parameter int FRAC_BITS = psc_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psc_in_if.sink      i_in,
    psc_out_if.source   o_out,
    psc_cfg_if.sink     i_cfg
);
    import psc_pkg::*;

    t_plane                   r_plane;
    logic                     en;
    logic                     dist_v, div_v, out_v;
    logic signed [DIST_W-1:0] d0;
    logic signed [DEN_W-1:0]  den;
    t_side                    dist_side, div_side;
    logic signed [CW-1:0]     t;
    t_out                     out_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '{pp_x: '0, pp_y: '0, pp_z: '0,
                         n_x: '0, n_y: '0, n_z: NORMAL_Z_RESET};
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PP_X: r_plane.pp_x <= i_cfg.data;
                REG_PP_Y: r_plane.pp_y <= i_cfg.data;
                REG_PP_Z: r_plane.pp_z <= i_cfg.data;
                REG_N_X:  r_plane.n_x  <= i_cfg.data;
                REG_N_Y:  r_plane.n_y  <= i_cfg.data;
                REG_N_Z:  r_plane.n_z  <= i_cfg.data;
                default:  r_plane      <= r_plane;
            endcase
        end
    end

    assign en         = o_out.ready | ~out_v;
    assign i_in.ready = en;

    psc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_data  (i_in.data),
        .i_plane (r_plane),
        .o_valid (dist_v),
        .o_d0    (d0),
        .o_den   (den),
        .o_side  (dist_side)
    );

    psc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dist_v),
        .i_d0    (d0),
        .i_den   (den),
        .i_side  (dist_side),
        .o_valid (div_v),
        .o_t     (t),
        .o_side  (div_side)
    );

    psc_interp #(.FRAC_BITS(FRAC_BITS)) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_v),
        .i_t     (t),
        .i_side  (div_side),
        .o_valid (out_v),
        .o_data  (out_data)
    );

    assign o_out.valid = out_v;
    assign o_out.data  = out_data;

endmodule

[src/psc_checker.sv]
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks of the plane segment clipper, bound to the top level.
// ----------------------------------------------------------------------------
module psc_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_ready,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  psc_pkg::t_out i_out_data
);
    import psc_pkg::*;

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data));
    endproperty
    a_hold: assert property (p_hold) else $error("Stalled output beat changed.");

    property p_ready;
        @(posedge i_clk) disable iff (!i_rst_n)
            !i_in_ready |-> (i_out_valid && !i_out_ready);
    endproperty
    a_ready: assert property (p_ready) else $error("Input stalled without output stall.");

    property p_par_t;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_out_valid && i_out_data.is_parallel) |->
                (i_out_data.param_t == '0 &&
                 i_out_data.start_inside == i_out_data.end_inside);
    endproperty
    a_par_t: assert property (p_par_t) else $error("Parallel beat has bad t or flags.");

    property p_reset;
        @(posedge i_clk) !i_rst_n |=> !i_out_valid;
    endproperty
    a_reset: assert property (p_reset) else $error("Output valid after reset.");

endmodule

bind plane_segment_clip_top psc_checker u_psc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
